// File: design/rrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative record locator package
// Shared constants, codes and types for the relative record locator.
// ----------------------------------------------------------------------------
package rrl_pkg;

   // Data-block table geometry.
   localparam int unsigned MAX_BLOCKS = 4096;
   localparam int unsigned ADDR_W     = $clog2(MAX_BLOCKS);

   // Payload bytes held by one data block.
   localparam int unsigned BLOCK_DATA_BYTES = 254;

   // Byte offset of a record start: 16-bit record times 8-bit length.
   localparam int unsigned BYTE_OFF_W = 24;

   // Block index of a byte offset; wide enough to compare with any table size.
   localparam int unsigned BLK_W = 17;

   // Division by the block size is done with a scaled reciprocal.
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned RECIP_W     = 25;
   localparam int unsigned PROD_W      = BYTE_OFF_W + RECIP_W;
   localparam logic [RECIP_W-1:0] BLOCK_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / BLOCK_DATA_BYTES);

   // Request actions.
   localparam logic [1:0] ACT_LOAD     = 2'd0;
   localparam logic [1:0] ACT_TAG      = 2'd1;
   localparam logic [1:0] ACT_POSITION = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_POS_ERR  = 2'd1;
   localparam logic [1:0] STATUS_PAST_END = 2'd2;
   localparam logic [1:0] STATUS_NO_BLOCK = 2'd3;

   // Buffer decisions.
   localparam logic [1:0] BUF_REUSE = 2'd0;
   localparam logic [1:0] BUF_SWAP  = 2'd1;
   localparam logic [1:0] BUF_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CSR_RECORD_LENGTH = 1'b0;
   localparam logic [0:0] CSR_RECORD_COUNT  = 1'b1;

   // Control sequencer states.
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CALC,
      FSM_DONE
   } fsm_type;

   // Record start location produced by the offset unit.
   typedef struct packed {
      logic [BLK_W-1:0] block;
      logic [7:0]       offset;
   } loc_type;

endpackage

// File: design/relative_record_locator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative record locator unit
// Locates a fixed-length record of a relative file in its data-block table
// and decides how the two sector buffers are used for it.
// ----------------------------------------------------------------------------
// Sequence: a position transaction shows its result after the offset pipeline
//   and the table read, or straight away when the position or record check fails;
//   load and tag transactions complete in the accepting cycle and give no result.
// Throughput: one transaction at a time; a position transaction occupies the
//   unit through the three-stage offset pipeline, the registered table read and
//   the wait for the result register. Load and tag are taken every cycle while idle.
// Reset: synchronous, active high; clears control, buffer tags and configuration registers.
//   The block table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module relative_record_locator_unit
   import rrl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_block_index,
   input  logic [7:0]  req_track,
   input  logic [7:0]  req_sector,
   input  logic [7:0]  req_record_low,
   input  logic [7:0]  req_record_high,
   input  logic [7:0]  req_offset_in_record,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_found_track,
   output logic [7:0]  rsp_found_sector,
   output logic [1:0]  rsp_buffer_action,
   output logic [8:0]  rsp_buffer_pointer,
   output logic [8:0]  rsp_record_end,
   output logic        rsp_spans_next,

   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // ------------------------------------------------------------------------
   // Configuration registers. Writes must only happen while the unit is idle; the unit does not enforce it.
   // ------------------------------------------------------------------------
   logic [7:0]  record_length_ff;
   logic [15:0] record_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= 8'd1;
         record_count_ff  <= 16'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RECORD_LENGTH: record_length_ff <= csr_wdata[7:0];
            CSR_RECORD_COUNT:  record_count_ff  <= csr_wdata;
            default:           record_count_ff  <= record_count_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Request decode. Record numbers and byte positions are one based on the
   // interface, with zero treated the same as one.
   // ------------------------------------------------------------------------
   fsm_type state_ff;
   fsm_type state_in;

   logic        req_accept;
   logic        is_load;
   logic        is_tag;
   logic        is_position;
   logic [7:0]  pos_zb;
   logic [15:0] rec_raw;
   logic [15:0] rec_zb;
   logic        pos_err;
   logic        end_err;
   logic [1:0]  req_status;

   assign req_accept  = req_valid && req_ready;
   assign is_load     = (req_action == ACT_LOAD);
   assign is_tag      = (req_action == ACT_TAG);
   assign is_position = (req_action == ACT_POSITION);

   always_comb begin
      rec_raw = {req_record_high, req_record_low};
      pos_zb  = (req_offset_in_record == 8'd0) ? 8'd0 : req_offset_in_record - 8'd1;
      rec_zb  = (rec_raw == 16'd0) ? 16'd0 : rec_raw - 16'd1;
      pos_err = (pos_zb >= record_length_ff);
      end_err = (rec_zb >= record_count_ff);
      // The position check wins over the record-count check.
      priority if (pos_err) begin
         req_status = STATUS_POS_ERR;
      end else if (end_err) begin
         req_status = STATUS_PAST_END;
      end else begin
         req_status = STATUS_OK;
      end
   end

   // ------------------------------------------------------------------------
   // Offset pipeline: record start as block index and byte within block.
   // ------------------------------------------------------------------------
   logic    loc_start;
   logic    loc_done;
   loc_type loc;

   rrl_locate u_locate (
      .clock   (clock),
      .reset   (reset),
      .start_i (loc_start),
      .rec_i   (rec_zb),
      .len_i   (record_length_ff),
      .done_o  (loc_done),
      .loc_o   (loc)
   );

   logic block_beyond;
   assign block_beyond = (loc.block >= BLK_W'(MAX_BLOCKS));

   // ------------------------------------------------------------------------
   // Block pointer table: one write port for load transactions, one read
   // port addressed by the located block. The read runs every cycle; the
   // address is held stable by the offset pipeline while a lookup is open.
   // ------------------------------------------------------------------------
   logic [15:0]       block_ptr_mem [MAX_BLOCKS];
   logic [15:0]       rd_data_ff;
   logic              tbl_we;
   logic [ADDR_W-1:0] tbl_waddr;
   logic [ADDR_W-1:0] tbl_raddr;

   assign tbl_we    = req_accept && is_load &&
                      ({5'd0, req_block_index} < BLK_W'(MAX_BLOCKS));
   assign tbl_waddr = ADDR_W'(req_block_index);
   assign tbl_raddr = ADDR_W'(loc.block);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         block_ptr_mem[tbl_waddr] <= {req_track, req_sector};
      end
      rd_data_ff <= block_ptr_mem[tbl_raddr];
   end

   // ------------------------------------------------------------------------
   // Sequencer. Idle takes any transaction; a position transaction either
   // fails its checks at once or waits in CALC for the offset pipeline, then
   // sits in DONE until the result register can take the answer.
   // ------------------------------------------------------------------------
   logic rsp_load;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_accept && is_position) begin
               state_in = (req_status == STATUS_OK) ? FSM_CALC : FSM_DONE;
            end
         end
         FSM_CALC: begin
            if (loc_done) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (rsp_load) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         FSM_IDLE: req_ready = 1'b1;
         FSM_CALC: req_ready = 1'b0;
         FSM_DONE: rsp_load  = !rsp_valid || rsp_ready;
         default:  req_ready = 1'b0;
      endcase
   end

   assign loc_start = req_accept && is_position && (req_status == STATUS_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Per-transaction context: zero-based position, running status and the
   // last selected record. The record is remembered whenever the position
   // check passes, even if the record then proves to lie beyond the file.
   // ------------------------------------------------------------------------
   logic [7:0]  pos_ff;
   logic [1:0]  status_ff;
   logic [1:0]  status_in;
   logic [15:0] selected_record_ff;

   always_comb begin
      status_in = status_ff;
      if (req_accept && is_position) begin
         status_in = req_status;
      end else if ((state_ff == FSM_CALC) && loc_done && block_beyond) begin
         status_in = STATUS_NO_BLOCK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff          <= STATUS_OK;
         selected_record_ff <= 16'd0;
      end else begin
         status_ff <= status_in;
         if (req_accept && is_position && !pos_err) begin
            selected_record_ff <= rec_zb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_position) begin
         pos_ff <= pos_zb;
      end
   end

   // ------------------------------------------------------------------------
   // Buffer decision. A hit on the next tag swaps the two buffers; otherwise
   // a miss on the current tag forces a read into the current buffer.
   // ------------------------------------------------------------------------
   logic [7:0] cur_track_ff;
   logic [7:0] cur_sector_ff;
   logic [7:0] next_track_ff;
   logic [7:0] next_sector_ff;
   logic [7:0] cur_track_in;
   logic [7:0] cur_sector_in;
   logic [7:0] next_track_in;
   logic [7:0] next_sector_in;

   logic [7:0] found_track;
   logic [7:0] found_sector;
   logic       hit_next;
   logic       hit_cur;
   logic       done_ok;
   logic [1:0] buf_action;
   logic [8:0] buf_ptr;
   logic [8:0] rec_end;

   always_comb begin
      found_track  = rd_data_ff[15:8];
      found_sector = rd_data_ff[7:0];
      hit_next     = (next_track_ff == found_track) && (next_sector_ff == found_sector);
      hit_cur      = (cur_track_ff == found_track) && (cur_sector_ff == found_sector);
      done_ok      = (status_ff == STATUS_OK);
      buf_ptr      = 9'(loc.offset) + 9'd2 + 9'(pos_ff);
      rec_end      = 9'(loc.offset) + 9'd2 + 9'(record_length_ff);

      cur_track_in   = cur_track_ff;
      cur_sector_in  = cur_sector_ff;
      next_track_in  = next_track_ff;
      next_sector_in = next_sector_ff;

      priority if (hit_next) begin
         buf_action = BUF_SWAP;
      end else if (!hit_cur) begin
         buf_action = BUF_READ;
      end else begin
         buf_action = BUF_REUSE;
      end

      if (req_accept && is_tag) begin
         next_track_in  = req_track;
         next_sector_in = req_sector;
      end else if (rsp_load && done_ok) begin
         cur_track_in  = found_track;
         cur_sector_in = found_sector;
         if (hit_next) begin
            next_track_in  = cur_track_ff;
            next_sector_in = cur_sector_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_track_ff   <= 8'd0;
         cur_sector_ff  <= 8'd0;
         next_track_ff  <= 8'd0;
         next_sector_ff <= 8'd0;
      end else begin
         cur_track_ff   <= cur_track_in;
         cur_sector_ff  <= cur_sector_in;
         next_track_ff  <= next_track_in;
         next_sector_ff <= next_sector_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register. Failed lookups report only their status.
   // ------------------------------------------------------------------------
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_found_track_ff;
   logic [7:0] rsp_found_sector_ff;
   logic [1:0] rsp_buffer_action_ff;
   logic [8:0] rsp_buffer_pointer_ff;
   logic [8:0] rsp_record_end_ff;
   logic       rsp_spans_next_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         if (done_ok) begin
            rsp_found_track_ff    <= found_track;
            rsp_found_sector_ff   <= found_sector;
            rsp_buffer_action_ff  <= buf_action;
            rsp_buffer_pointer_ff <= buf_ptr;
            rsp_record_end_ff     <= rec_end;
            rsp_spans_next_ff     <= (rec_end >= 9'd257);
         end else begin
            rsp_found_track_ff    <= 8'd0;
            rsp_found_sector_ff   <= 8'd0;
            rsp_buffer_action_ff  <= BUF_REUSE;
            rsp_buffer_pointer_ff <= 9'd0;
            rsp_record_end_ff     <= 9'd0;
            rsp_spans_next_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_track    = rsp_found_track_ff;
   assign rsp_found_sector   = rsp_found_sector_ff;
   assign rsp_buffer_action  = rsp_buffer_action_ff;
   assign rsp_buffer_pointer = rsp_buffer_pointer_ff;
   assign rsp_record_end     = rsp_record_end_ff;
   assign rsp_spans_next     = rsp_spans_next_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_DONE))
      else $error("result raised outside the completion state");

   a_current_tag_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && done_ok) |=>
         (cur_track_ff == rsp_found_track_ff) && (cur_sector_ff == rsp_found_sector_ff))
      else $error("current buffer tag does not match delivered block");

   a_ok_within_file: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && done_ok) |-> (selected_record_ff < record_count_ff))
      else $error("successful lookup of a record beyond the file");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |->
         (rsp_found_track_ff == 8'd0) && (rsp_buffer_pointer_ff == 9'd0) &&
         (rsp_record_end_ff == 9'd0) && !rsp_spans_next_ff)
      else $error("failed lookup carries nonzero fields");

endmodule

// File: design/rrl_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record start locator
// Three-stage pipeline: record times length, reciprocal multiply by 1/254,
// then a single quotient correction giving block index and in-block offset.
// ----------------------------------------------------------------------------
module rrl_locate
   import rrl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start_i,
   input  logic [15:0] rec_i,
   input  logic [7:0]  len_i,
   output logic        done_o,
   output loc_type     loc_o
);

   logic                  s1_valid_ff;
   logic                  s2_valid_ff;
   logic                  done_ff;
   logic [BYTE_OFF_W-1:0] byte_off_ff;
   logic [BYTE_OFF_W-1:0] byte_off2_ff;
   logic [PROD_W-1:0]     prod_ff;
   loc_type               loc_ff;

   logic [BLK_W-1:0]      q_est;
   logic [BYTE_OFF_W-1:0] rem_wide;
   logic [8:0]            rem;
   loc_type               loc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= start_i;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         byte_off_ff <= BYTE_OFF_W'(rec_i) * BYTE_OFF_W'(len_i);
      end
      if (s1_valid_ff) begin
         prod_ff      <= PROD_W'(byte_off_ff) * PROD_W'(BLOCK_RECIP);
         byte_off2_ff <= byte_off_ff;
      end
      if (s2_valid_ff) begin
         loc_ff <= loc_in;
      end
   end

   // The truncated reciprocal underestimates the quotient by at most one.
   always_comb begin
      q_est    = prod_ff[RECIP_SHIFT +: BLK_W];
      rem_wide = byte_off2_ff -
                 (BYTE_OFF_W'(q_est) * BYTE_OFF_W'(BLOCK_DATA_BYTES));
      rem      = rem_wide[8:0];
      if (rem >= 9'(BLOCK_DATA_BYTES)) begin
         loc_in.block  = q_est + BLK_W'(1);
         loc_in.offset = 8'(rem - 9'(BLOCK_DATA_BYTES));
      end else begin
         loc_in.block  = q_est;
         loc_in.offset = rem[7:0];
      end
   end

   assign done_o = done_ff;
   assign loc_o  = loc_ff;

   a_done_follows_start: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(start_i, 3))
      else $error("locate result without a matching start");

   a_offset_in_block: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (loc_ff.offset < 8'(BLOCK_DATA_BYTES)))
      else $error("in-block offset not below block size");

endmodule
